/* sv/mmu_pkg.sv */
package mmu_pkg;
  localparam int unsigned OpW  = 16;
  localparam int unsigned SumW = 35;
  localparam int unsigned IdxW = 3;

  typedef enum logic [3:0] {
    CfgRows  = 4'd0,
    CfgInner = 4'd1,
    CfgCols  = 4'd2,
    CfgTrans = 4'd3
  } cfg_index_t;

  // control handed from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic acc;
  } cell_ctl_t;
endpackage

/* sv/mmu_ram.sv */
module mmu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/mmu_cell.sv */
module mmu_cell import mmu_pkg::*; (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic signed [OpW-1:0]  a_in,
  input  logic signed [OpW-1:0]  b,
  output logic signed [OpW-1:0]  a_out,
  output logic signed [SumW-1:0] acc
);
  logic signed [2*OpW-1:0] prod;

  // pass the left operand on and multiply it by this column's operand
  always_ff @(posedge clk) begin
    a_out <= a_in;
    prod  <= a_in * b;
  end

  // accumulate one product a cycle while ctl.acc is set
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc) begin
      acc <= acc + SumW'(prod);
    end
  end
endmodule

/* sv/matrix_multiply_unit.sv */
// Elements load one per cycle (busy stays low). A start_multiply item sets busy:
// for each result row the left row streams across a chain of MAX_DIM cells, one
// per column, each holding its own copy of a right-matrix column and row and its
// own accumulator; the inner index steps down the chain beside the left operand.
// Each row passes through S_FEED, S_WAIT and S_EMIT; its column_count results leave
// one a cycle from the output register. Busy stays high until the last row's S_EMIT
// ends (counts after clamping), and the last result appears in the first cycle
// with busy low. Registers accept writes only while busy is low. The receiver
// cannot stall: each result strobes valid for exactly one cycle.
module matrix_multiply_unit import mmu_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [IdxW-1:0]        row_index,
  input  logic [IdxW-1:0]        column_index,
  input  logic signed [OpW-1:0]  operand_value,
  input  logic                   start_multiply,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  output logic                   valid,
  output logic [IdxW-1:0]        out_row,
  output logic [IdxW-1:0]        out_column,
  output logic signed [SumW-1:0] dot_sum,
  output logic                   end_of_run
);
  localparam int unsigned DW = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
  localparam int unsigned AW = 2 * DW;
  localparam int unsigned CW = 4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FEED = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  logic [3:0] row_count, inner_count, column_count;
  logic right_transposed;
  logic [CW-1:0] rows, inner, cols, rlim, clim;
  logic [CW-1:0] r, k, c, wcnt;
  logic in_range, accept, le_we, ri_we;

  assign cfg_ready = !busy;
  assign busy = (state != S_IDLE);
  assign accept = start && !busy;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 4'd8; inner_count <= 4'd8; column_count <= 4'd8;
      right_transposed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'({2'b00, cfg_index}))
        CfgRows:  row_count <= cfg_data;
        CfgInner: inner_count <= cfg_data;
        CfgCols:  column_count <= cfg_data;
        CfgTrans: right_transposed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [CW-1:0] clampc(input logic [3:0] v);
    if (v == 4'd0) return CW'(1);
    if (v > CW'(MAX_DIM)) return CW'(MAX_DIM);
    return v;
  endfunction

  assign rows  = clampc(row_count);
  assign inner = clampc(inner_count);
  assign cols  = clampc(column_count);

  // bounds of the element's matrix
  always_comb begin
    if (!kind) begin
      rlim = rows; clim = inner;
    end else if (right_transposed) begin
      rlim = cols; clim = inner;
    end else begin
      rlim = inner; clim = cols;
    end
  end
  assign in_range = ({1'b0, row_index} < rlim) && ({1'b0, column_index} < clim);
  assign le_we = accept && in_range && !kind;
  assign ri_we = accept && in_range && kind;

  // left store: a memory read once per inner step
  logic [AW-1:0] l_raddr;
  logic signed [OpW-1:0] l_rdata;
  assign l_raddr = {r[DW-1:0], k[DW-1:0]};
  mmu_ram #(.Width(OpW), .Depth(1 << AW)) u_left (
    .clk(clk), .we(le_we), .waddr({row_index[DW-1:0], column_index[DW-1:0]}),
    .wdata(operand_value), .raddr(l_raddr), .rdata(l_rdata));

  // sequencer
  logic feed_v;
  logic [DW-1:0] k1;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      feed_v <= 1'b0;
    end else begin
      feed_v <= (state == S_FEED);
      case (state)
        S_IDLE: if (accept && start_multiply) begin
          state <= S_FEED; r <= '0; k <= '0;
        end
        S_FEED: begin
          if (k + CW'(1) == inner) begin
            state <= S_WAIT; wcnt <= '0;
          end
          k <= k + CW'(1);
        end
        S_WAIT: begin
          wcnt <= wcnt + CW'(1);
          if (wcnt == CW'(3)) begin
            state <= S_EMIT; c <= '0;
          end
        end
        S_EMIT: begin
          c <= c + CW'(1);
          if (c + CW'(1) == cols) begin
            if (r + CW'(1) == rows) state <= S_IDLE;
            else begin
              state <= S_FEED; r <= r + CW'(1); k <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // inner index aligned with the ram read data
  always_ff @(posedge clk) k1 <= k[DW-1:0];

  // chain of cells: left operand ripples; inner index follows it per cell
  cell_ctl_t ctl [MAX_DIM];
  logic signed [OpW-1:0] a_ch [MAX_DIM+1];
  logic signed [OpW-1:0] bsel [MAX_DIM];
  logic signed [SumW-1:0] accs [MAX_DIM];
  logic [DW-1:0] kd [MAX_DIM+1];
  logic vd [MAX_DIM+1];
  logic start_row;
  assign start_row = (state == S_FEED) && (k == '0);
  assign a_ch[0] = l_rdata;
  assign kd[0] = k1;
  assign vd[0] = feed_v;

  genvar g;
  generate
    for (g = 0; g < MAX_DIM; g++) begin : g_cell
      // right operands of this column: bank_n by inner row, bank_t by inner column
      logic signed [OpW-1:0] bank_n [MAX_DIM];
      logic signed [OpW-1:0] bank_t [MAX_DIM];
      always_ff @(posedge clk) begin
        if (ri_we && column_index[DW-1:0] == DW'(g)) begin
          bank_n[row_index[DW-1:0]] <= operand_value;
        end
        if (ri_we && row_index[DW-1:0] == DW'(g)) begin
          bank_t[column_index[DW-1:0]] <= operand_value;
        end
      end

      // skew registers follow the operand down the chain
      always_ff @(posedge clk) begin
        kd[g+1] <= kd[g];
        vd[g+1] <= rst ? 1'b0 : vd[g];
      end
      assign bsel[g] = right_transposed ? bank_t[kd[g]] : bank_n[kd[g]];
      assign ctl[g].clear = start_row;
      assign ctl[g].acc = vd[g+1];
      mmu_cell u_cell (
        .clk(clk), .ctl(ctl[g]), .a_in(a_ch[g]),
        .b(bsel[g]), .a_out(a_ch[g+1]), .acc(accs[g]));
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else valid <= (state == S_EMIT);
    out_row <= r[IdxW-1:0];
    out_column <= c[IdxW-1:0];
    dot_sum <= accs[c[DW-1:0]];
    end_of_run <= (r + CW'(1) == rows) && (c + CW'(1) == cols);
  end
endmodule

/* tb/mmu_checker.sv */
`timescale 1ns / 1ps

module mmu_checker import mmu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   kind,
  input  logic [IdxW-1:0]        row_index,
  input  logic [IdxW-1:0]        column_index,
  input  logic signed [OpW-1:0]  operand_value,
  input  logic                   start_multiply,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  input  logic                   valid,
  input  logic [IdxW-1:0]        out_row,
  input  logic [IdxW-1:0]        out_column,
  input  logic signed [SumW-1:0] dot_sum,
  input  logic                   end_of_run,
  output int                     error_count,
  output int                     pending
);

  localparam int Dim = 8;

  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] column;
    logic [SumW-1:0] sum;
    logic            last;
  } product_t;

  logic signed [OpW-1:0] left_mem  [Dim*Dim];
  logic signed [OpW-1:0] right_mem [Dim*Dim];
  logic [3:0] rows_reg, inner_reg, cols_reg;
  logic       trans_reg;
  product_t   product_q [$];

  // zero acts as one, above the array size saturates
  function automatic int eff_count(logic [3:0] v);
    if (v == 0) return 1;
    if (v > Dim) return Dim;
    return int'(v);
  endfunction

  // store the element, then on a start mark queue every dot product
  task automatic load_and_multiply();
    int rows, inner, cols, rlim, clim, ra;
    longint acc;
    product_t p;
    rows  = eff_count(rows_reg);
    inner = eff_count(inner_reg);
    cols  = eff_count(cols_reg);
    if (!kind) begin
      rlim = rows;  clim = inner;
    end else if (trans_reg) begin
      rlim = cols;  clim = inner;
    end else begin
      rlim = inner; clim = cols;
    end
    if (row_index < rlim && column_index < clim) begin
      if (!kind) left_mem[row_index*Dim + column_index] = operand_value;
      else right_mem[row_index*Dim + column_index] = operand_value;
    end
    if (start_multiply) begin
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          acc = 0;
          for (int k = 0; k < inner; k++) begin
            ra = trans_reg ? c*Dim + k : k*Dim + c;
            acc += longint'(left_mem[r*Dim + k]) * longint'(right_mem[ra]);
          end
          p.row    = IdxW'(r);
          p.column = IdxW'(c);
          p.sum    = SumW'(acc);
          p.last   = (r == rows-1) && (c == cols-1);
          product_q = {product_q, p};
        end
      end
    end
  endtask

  always @(posedge clk) begin
    product_t exp_p;
    if (rst) begin
      rows_reg = 4'd8; inner_reg = 4'd8; cols_reg = 4'd8; trans_reg = 1'b0;
      product_q.delete();
      error_count = 0;
    end else begin
      // result beat against oldest prediction
      if (valid) begin
        if (product_q.size() == 0) begin
          $error("unexpected result row=%0d col=%0d sum=%0d", out_row, out_column, dot_sum);
          error_count++;
        end else begin
          exp_p = product_q.pop_front();
          if (out_row !== exp_p.row) begin
            $error("out_row expected %0d actual %0d", exp_p.row, out_row);
            error_count++;
          end
          if (out_column !== exp_p.column) begin
            $error("out_column expected %0d actual %0d", exp_p.column, out_column);
            error_count++;
          end
          if (dot_sum !== $signed(exp_p.sum)) begin
            $error("dot_sum expected %0d actual %0d", $signed(exp_p.sum), dot_sum);
            error_count++;
          end
          if (end_of_run !== exp_p.last) begin
            $error("end_of_run expected %0b actual %0b", exp_p.last, end_of_run);
            error_count++;
          end
        end
      end
      // element beat, seen with the registers as they stood before this edge
      if (start && !busy) load_and_multiply();
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'({2'b00, cfg_index}))
          CfgRows:  rows_reg  = cfg_data;
          CfgInner: inner_reg = cfg_data;
          CfgCols:  cols_reg  = cfg_data;
          CfgTrans: trans_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = product_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mmu_pkg::*;

  localparam int StallLimit = 5000;

  logic                   clk, rst;
  logic                   start, busy;
  logic                   kind;
  logic [IdxW-1:0]        row_index, column_index;
  logic signed [OpW-1:0]  operand_value;
  logic                   start_multiply;
  logic                   cfg_valid, cfg_ready;
  logic [1:0]             cfg_index;
  logic [3:0]             cfg_data;
  logic                   valid;
  logic [IdxW-1:0]        out_row, out_column;
  logic signed [SumW-1:0] dot_sum;
  logic                   end_of_run;
  int                     error_count, pending;
  int                     sent_items;
  int                     stall_cycles;

  matrix_multiply_unit uut (.*);

  mmu_checker checker_i (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles where no beat moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // one element beat; start stays high across back-to-back beats
  task automatic send_item(logic k, int r, int c, logic signed [OpW-1:0] v, logic go);
    int g;
    start          <= 1'b1;
    kind           <= k;
    row_index      <= IdxW'(r);
    column_index   <= IdxW'(c);
    operand_value  <= v;
    start_multiply <= go;
    do @(posedge clk); while (busy);
    sent_items++;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait for all results, then drain any work still in flight
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [3:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(logic [3:0] r, logic [3:0] i, logic [3:0] c, logic t);
    write_reg(CfgRows, r);
    write_reg(CfgInner, i);
    write_reg(CfgCols, c);
    write_reg(CfgTrans, {3'b000, t});
  endtask

  function automatic logic signed [OpW-1:0] rand_value();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 16'sh8000;
    if (p == 1) return 16'sh7fff;
    return OpW'($urandom);
  endfunction

  function automatic logic [3:0] rand_count();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 4'd0;
    if (p == 1) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(8, 1));
  endfunction

  initial begin
    int n, go_at;
    logic signed [OpW-1:0] v;
    start = 1'b0; kind = 1'b0; row_index = '0; column_index = '0;
    operand_value = '0; start_multiply = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    sent_items = 0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both stores at full size; most negative values give the largest sum
    for (int k = 0; k < 2; k++)
      for (int a = 0; a < 64; a++)
        send_item(k[0], a / 8, a % 8, 16'sh8000, (k == 1) && (a == 63));
    settle();

    // positive extreme against negative extreme, transposed weight layout
    set_shape(4'd8, 4'd8, 4'd8, 1'b1);
    for (int a = 0; a < 8; a++) send_item(1'b0, 0, a, 16'sh7fff, 1'b0);
    send_item(1'b1, 7, 7, 16'sh7fff, 1'b1);
    settle();

    // zero counts act as one; element outside sizes still honors its start mark
    set_shape(4'd0, 4'd0, 4'd0, 1'b0);
    send_item(1'b0, 0, 0, 16'sd3, 1'b0);
    send_item(1'b1, 5, 6, 16'sd9, 1'b1);
    settle();

    // counts above the array saturate
    set_shape(4'd15, 4'd12, 4'd9, 1'b0);
    send_item(1'b1, 3, 4, 16'sh1234, 1'b1);
    settle();

    // random shapes, loads and multiplies
    while (sent_items < 230) begin
      if ($urandom_range(2) != 0)
        set_shape(rand_count(), rand_count(), rand_count(), 1'($urandom));
      n = $urandom_range(12, 1);
      go_at = n - 1;
      for (int i = 0; i < n; i++) begin
        v = rand_value();
        if ($urandom_range(9) < 8)
          send_item(1'($urandom), $urandom_range(3), $urandom_range(3), v, i == go_at);
        else
          send_item(1'($urandom), $urandom_range(7), $urandom_range(7), v,
                    (i == go_at) || ($urandom_range(19) == 0));
      end
      settle();
    end

    if (error_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/mmu_pkg.sv
sv/mmu_ram.sv
sv/mmu_cell.sv
sv/matrix_multiply_unit.sv
tb/mmu_checker.sv
tb/testbench.sv
